/* src/asgm_pkg.sv */
package asgm_pkg;

  // Field and datapath widths
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int TIME_W     = 32;
  localparam int SCALE_W    = 16;
  localparam int DEB_W      = 8;
  localparam int VALUE_W    = 32;
  localparam int PROD_W     = SCALE_W + COUNT_BITS;
  localparam int NUM_W      = PROD_W + FRAC_BITS;

  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [SCALE_W-1:0]    scale_t;
  typedef logic [DEB_W-1:0]      deb_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [NUM_W-1:0]      num_t;
  typedef logic [VALUE_W-1:0]    value_t;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_PULSE = 2'd0,
    OP_SPEED = 2'd1,
    OP_GUST  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam logic [0:0] REG_DEBOUNCE = 1'b0;
  localparam logic [0:0] REG_SCALE    = 1'b1;

  // Result kinds
  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_GUST  = 1'b1;

  // Reset values
  localparam deb_t   DEBOUNCE_RESET = 8'd10;
  localparam scale_t SCALE_RESET    = 16'd1492;
  localparam time_t  NO_PERIOD      = '1;

  // Commands from the sequencer to the pulse tracker
  typedef struct packed {
    logic go;
    logic clear_count;
    logic clear_gust;
  } pulse_cmd_t;

  // Status from the pulse tracker
  typedef struct packed {
    logic   done;
    count_t count;
    time_t  shortest;
  } pulse_stat_t;

endpackage

/* src/asgm_pulse.sv */
module asgm_pulse (
  input  logic                 clk,
  input  logic                 rst,
  input  asgm_pkg::pulse_cmd_t cmd,
  input  asgm_pkg::time_t      time_ms,
  input  asgm_pkg::deb_t       debounce_ms,
  output asgm_pkg::pulse_stat_t stat
);

  asgm_pkg::time_t  last_pulse_time;
  logic             half_turn_phase;
  logic             have_rotation_time;
  asgm_pkg::time_t  rotation_start_time;
  asgm_pkg::count_t rotation_count;
  asgm_pkg::time_t  shortest_period;
  logic             pend;
  logic             accept_q;
  asgm_pkg::time_t  now_q;

  asgm_pkg::time_t  since;
  logic             since_ok;
  asgm_pkg::time_t  period;

  // On a pulse request: debounce check against the last accepted pulse.
  assign since    = time_ms - last_pulse_time;
  assign since_ok = since > asgm_pkg::time_t'(debounce_ms);

  // Update step, from the registered timestamp: rotation period since the start of the current turn.
  assign period = now_q - rotation_start_time;

  // Pulse timestamp, held for the update cycle.
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      now_q <= time_ms;
    end
  end

  // Pulse state update and clears requested by the read paths.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time     <= '0;
      half_turn_phase     <= 1'b0;
      have_rotation_time  <= 1'b0;
      rotation_start_time <= '1;
      rotation_count      <= '0;
      shortest_period     <= asgm_pkg::NO_PERIOD;
      pend                <= 1'b0;
      accept_q            <= 1'b0;
    end else begin
      pend <= cmd.go;
      if (cmd.go) begin
        accept_q <= since_ok;
      end
      if (pend && accept_q) begin
        if (!half_turn_phase) begin
          if (have_rotation_time && (period < shortest_period)) begin
            shortest_period <= period;
          end
          if (rotation_count != '1) begin
            rotation_count <= rotation_count + 1'b1;
          end
          rotation_start_time <= now_q;
          have_rotation_time  <= 1'b1;
          half_turn_phase     <= 1'b1;
        end else begin
          half_turn_phase <= 1'b0;
        end
        last_pulse_time <= now_q;
      end
      if (cmd.clear_count) begin
        rotation_count <= '0;
      end
      if (cmd.clear_gust) begin
        shortest_period <= asgm_pkg::NO_PERIOD;
      end
    end
  end

  assign stat.done     = pend;
  assign stat.count    = rotation_count;
  assign stat.shortest = shortest_period;

endmodule

/* src/asgm_mul.sv */
module asgm_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  asgm_pkg::scale_t  scale,
  input  asgm_pkg::count_t  count,
  output logic              done,
  output asgm_pkg::prod_t   product
);

  localparam int MCNT_W = $clog2(asgm_pkg::SCALE_W + 1);

  logic                busy;
  logic [MCNT_W-1:0]   cnt;
  asgm_pkg::count_t    mcand;
  asgm_pkg::scale_t    mplier;
  asgm_pkg::prod_t     acc;
  logic                done_q;

  // Shift-add multiplier, one bit of the scale per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (go) begin
      mcand  <= count;
      mplier <= scale;
      acc    <= '0;
    end else if (busy) begin
      acc    <= {acc[asgm_pkg::PROD_W-2:0], 1'b0} +
                (mplier[asgm_pkg::SCALE_W-1] ? asgm_pkg::prod_t'(mcand) : '0);
      mplier <= {mplier[asgm_pkg::SCALE_W-2:0], 1'b0};
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && (cnt == MCNT_W'(1));
      if (go) begin
        busy <= 1'b1;
        cnt  <= MCNT_W'(asgm_pkg::SCALE_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign done    = done_q;
  assign product = acc;

endmodule

/* src/asgm_div.sv */
module asgm_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  asgm_pkg::num_t   num,
  input  asgm_pkg::time_t  den,
  output logic             done,
  output asgm_pkg::value_t quotient
);

  localparam int DCNT_W = $clog2(asgm_pkg::NUM_W + 1);

  logic                      busy;
  logic [DCNT_W-1:0]         cnt;
  logic                      done_q;
  asgm_pkg::num_t            numsh;
  asgm_pkg::num_t            quo;
  asgm_pkg::time_t           rem;
  asgm_pkg::time_t           den_q;

  logic [asgm_pkg::TIME_W:0] trial;
  logic [asgm_pkg::TIME_W:0] diff;
  logic                      fits;

  // Restoring division step: bring down one numerator bit, subtract if it fits.
  assign trial = {rem, numsh[asgm_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (go) begin
      numsh <= num;
      den_q <= den;
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      numsh <= {numsh[asgm_pkg::NUM_W-2:0], 1'b0};
      rem   <= fits ? diff[asgm_pkg::TIME_W-1:0] : trial[asgm_pkg::TIME_W-1:0];
      quo   <= {quo[asgm_pkg::NUM_W-2:0], fits};
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && (cnt == DCNT_W'(1));
      if (go) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(asgm_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Saturate a quotient that does not fit the result field.
  generate
    if (asgm_pkg::NUM_W > asgm_pkg::VALUE_W) begin : g_sat
      assign quotient = (|quo[asgm_pkg::NUM_W-1:asgm_pkg::VALUE_W]) ? '1 :
                        quo[asgm_pkg::VALUE_W-1:0];
    end else begin : g_fit
      assign quotient = asgm_pkg::value_t'(quo);
    end
  endgenerate

  assign done = done_q;

endmodule

/* src/anemometer_speed_gust_meter.sv */
// Anemometer speed and gust meter.
// Input channel (in_valid/in_ready) carries one request: opcode and a millisecond
// timestamp. A pulse request updates the rotation tracking and gives no result; a
// speed or gust read gives exactly one result on the output channel
// (out_valid/out_ready) as result_kind and wind_value in 1/256 mph.
// One request is worked on at a time. A speed read runs a shift-add multiplier
// over the SCALE_W = 16 scale bits and then a radix-2 divider over the NUM_W = 40
// numerator bits. A gust read uses the divider alone. A speed read with zero
// elapsed time, or a gust read with no usable period, skips both and gives zero.
// The result sits in an output register, so the block takes the next request while
// a result waits; a further read finishes its work and then holds until the output
// register is taken. in_ready is low while a request is being worked on.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and are
// meant for idle periods. Reset clears all tracking state, empties the output and
// restores debounce 10 ms and scale 1492.
module anemometer_speed_gust_meter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [31:0] wind_value,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PULSE = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_RES   = 5'b10000
  } state_t;

  state_t                state;
  state_t                state_next;
  asgm_pkg::deb_t        debounce_ms;
  asgm_pkg::scale_t      speed_scale;
  asgm_pkg::time_t       window_start_time;
  asgm_pkg::time_t       den;
  asgm_pkg::value_t      res_value;
  logic                  res_kind;

  asgm_pkg::opcode_t     op;
  logic                  accept;
  asgm_pkg::time_t       elapsed;
  logic                  elapsed_zero;
  logic                  gust_ok;
  logic                  load_out;
  asgm_pkg::pulse_cmd_t  pulse_cmd;
  asgm_pkg::pulse_stat_t pulse_stat;
  logic                  mul_go;
  logic                  mul_done;
  asgm_pkg::prod_t       mul_product;
  logic                  div_go;
  logic                  div_done;
  asgm_pkg::num_t        div_num;
  asgm_pkg::time_t       div_den;
  asgm_pkg::value_t      div_quotient;

  // Request decode.
  assign in_ready     = (state == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign op           = asgm_pkg::opcode_t'(opcode);
  assign elapsed      = time_ms - window_start_time;
  assign elapsed_zero = (elapsed == '0);
  assign gust_ok      = (pulse_stat.shortest != asgm_pkg::NO_PERIOD) &&
                        (pulse_stat.shortest != '0);

  // Commands to the pulse tracker.
  assign pulse_cmd.go          = accept && (op == asgm_pkg::OP_PULSE);
  assign pulse_cmd.clear_count = accept && (op == asgm_pkg::OP_SPEED);
  assign pulse_cmd.clear_gust  = accept && (op == asgm_pkg::OP_GUST) && gust_ok;

  // Multiplier and divider starts; the divider numerator depends on the read kind.
  assign mul_go  = accept && (op == asgm_pkg::OP_SPEED) && !elapsed_zero;
  assign div_go  = mul_done || pulse_cmd.clear_gust;
  assign div_num = (state == ST_MUL) ?
                   (asgm_pkg::num_t'(mul_product) << asgm_pkg::FRAC_BITS) :
                   (asgm_pkg::num_t'(speed_scale) << asgm_pkg::FRAC_BITS);
  assign div_den = (state == ST_MUL) ? den : pulse_stat.shortest;

  assign load_out = (state == ST_RES) && (!out_valid || out_ready);

  asgm_pulse u_pulse (
    .clk         (clk),
    .rst         (rst),
    .cmd         (pulse_cmd),
    .time_ms     (time_ms),
    .debounce_ms (debounce_ms),
    .stat        (pulse_stat)
  );

  asgm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (mul_go),
    .scale   (speed_scale),
    .count   (pulse_stat.count),
    .done    (mul_done),
    .product (mul_product)
  );

  asgm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            asgm_pkg::OP_PULSE: state_next = ST_PULSE;
            asgm_pkg::OP_SPEED: state_next = elapsed_zero ? ST_RES : ST_MUL;
            asgm_pkg::OP_GUST:  state_next = gust_ok ? ST_DIV : ST_RES;
            default:            state_next = ST_IDLE;
          endcase
        end
      end
      ST_PULSE: begin
        if (pulse_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_RES;
        end
      end
      ST_RES: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state, configuration and the speed window.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      debounce_ms       <= asgm_pkg::DEBOUNCE_RESET;
      speed_scale       <= asgm_pkg::SCALE_RESET;
      window_start_time <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          asgm_pkg::REG_DEBOUNCE: debounce_ms <= cfg_data[asgm_pkg::DEB_W-1:0];
          asgm_pkg::REG_SCALE:    speed_scale <= cfg_data[asgm_pkg::SCALE_W-1:0];
          default:                ;
        endcase
      end
      if (pulse_cmd.clear_count) begin
        window_start_time <= time_ms;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: set on acceptance for the short cases, by the divider otherwise.
  always_ff @(posedge clk) begin
    if (accept && (op == asgm_pkg::OP_SPEED)) begin
      res_kind  <= asgm_pkg::KIND_SPEED;
      res_value <= '0;
      den       <= elapsed;
    end else if (accept && (op == asgm_pkg::OP_GUST)) begin
      res_kind  <= asgm_pkg::KIND_GUST;
      res_value <= '0;
    end else if (div_done) begin
      res_value <= div_quotient;
    end
    if (load_out) begin
      result_kind <= res_kind;
      wind_value  <= res_value;
    end
  end

  // The sequencer state stays one-hot.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state is not one-hot");

  // The multiplier finishes only while a speed read waits for it.
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MUL))
    else $error("multiplier finished outside a speed read");

  // The divider finishes only while a read waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside a read");

  // An unused opcode leaves the block ready for the next request.
  a_unused_op_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == asgm_pkg::OP_NONE)) |=> (state == ST_IDLE))
    else $error("unused opcode started work");

endmodule

/* tb/sv/anemometer_speed_gust_meter_test.sv */
`timescale 1ns / 1ps

module anemometer_speed_gust_meter_test;

  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 90;
  localparam int ERRORS_SHOWN  = 10;

  typedef struct packed {
    logic             kind;
    asgm_pkg::value_t value;
  } reading_t;

  // Mirrors the meter's tracking state and holds the readings it still owes.
  class wind_tracker;
    asgm_pkg::deb_t   debounce;
    asgm_pkg::scale_t scale;
    asgm_pkg::time_t  last_pulse;
    logic             half_turn;
    logic             turn_seen;
    asgm_pkg::time_t  turn_start;
    asgm_pkg::count_t turns;
    asgm_pkg::time_t  shortest;
    asgm_pkg::time_t  window_start;
    reading_t         due_readings[$];
    int               errors;

    function new();
      debounce     = asgm_pkg::DEBOUNCE_RESET;
      scale        = asgm_pkg::SCALE_RESET;
      last_pulse   = '0;
      half_turn    = 1'b0;
      turn_seen    = 1'b0;
      turn_start   = '1;
      turns        = '0;
      shortest     = asgm_pkg::NO_PERIOD;
      window_start = '0;
      errors       = 0;
    endfunction

    function void set_register(logic [0:0] index, logic [15:0] data);
      if (index == asgm_pkg::REG_DEBOUNCE) begin
        debounce = data[asgm_pkg::DEB_W-1:0];
      end else begin
        scale = data[asgm_pkg::SCALE_W-1:0];
      end
    endfunction

    // Advances the state for one accepted request and queues any reading it owes.
    function void note_request(asgm_pkg::opcode_t op, asgm_pkg::time_t now);
      asgm_pkg::time_t span;
      logic [63:0]     num;
      logic [63:0]     quo;
      reading_t        owed;
      case (op)
        asgm_pkg::OP_PULSE: begin
          span = now - last_pulse;
          if (span > asgm_pkg::time_t'(debounce)) begin
            if (!half_turn) begin
              if (turn_seen) begin
                span = now - turn_start;
                if (span < shortest) shortest = span;
              end
              if (turns != '1) turns = turns + 1'b1;
              turn_start = now;
              turn_seen  = 1'b1;
              half_turn  = 1'b1;
            end else begin
              half_turn = 1'b0;
            end
            last_pulse = now;
          end
        end
        asgm_pkg::OP_SPEED: begin
          owed.kind  = asgm_pkg::KIND_SPEED;
          owed.value = '0;
          span = now - window_start;
          if (span != 0) begin
            num = (64'(scale) * 64'(turns)) << asgm_pkg::FRAC_BITS;
            quo = num / 64'(span);
            owed.value = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
          end
          turns        = '0;
          window_start = now;
          due_readings.push_back(owed);
        end
        asgm_pkg::OP_GUST: begin
          owed.kind  = asgm_pkg::KIND_GUST;
          owed.value = '0;
          // An empty record or a zero period gives nought and leaves the record alone.
          if (shortest != asgm_pkg::NO_PERIOD && shortest != 0) begin
            num = 64'(scale) << asgm_pkg::FRAC_BITS;
            quo = num / 64'(shortest);
            owed.value = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
            shortest   = asgm_pkg::NO_PERIOD;
          end
          due_readings.push_back(owed);
        end
        default: ;
      endcase
    endfunction

    // Compares a delivered reading with the oldest one owed.
    function void check_reading(logic kind, asgm_pkg::value_t value);
      reading_t want;
      if (due_readings.size() == 0) begin
        errors++;
        if (errors <= ERRORS_SHOWN)
          $display("reading with none owed: kind %0d value %0d", kind, value);
        return;
      end
      want = due_readings.pop_front();
      if (kind !== want.kind || value !== want.value) begin
        errors++;
        if (errors <= ERRORS_SHOWN)
          $display("reading mismatch: kind expected %0d got %0d, value expected %0d got %0d",
                   want.kind, kind, want.value, value);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [31:0] time_ms;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [31:0] wind_value;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  wind_tracker     board;
  asgm_pkg::time_t clock_ms;
  bit              calm;
  bit              hold_results;

  anemometer_speed_gust_meter dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .time_ms     (time_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .wind_value  (wind_value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one, none at all in a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_request(asgm_pkg::opcode_t'(opcode), time_ms);
      if (out_valid && out_ready) board.check_reading(result_kind, wind_value);
    end
  end

  // Reading sink: random stalls, plus one long hold-off when asked for.
  initial begin : reading_sink
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_results = 1'b0;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall     = pick_gap();
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("anemometer_speed_gust_meter_test failed");
    $finish;
  end

  task automatic send_request(asgm_pkg::opcode_t op, asgm_pkg::time_t stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode   = op;
    time_ms  = stamp;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_register(logic [0:0] index, logic [15:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_register(index, data);
  endtask

  // Waits for every owed reading, then for any pulse still being worked on.
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (board.due_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Back-to-back pulses one millisecond apart.
  task automatic pulse_train(asgm_pkg::time_t first, int n);
    calm = 1'b1;
    for (int i = 0; i < n; i++) send_request(asgm_pkg::OP_PULSE, first + i);
    calm = 1'b0;
  endtask

  // Plausible traffic: pulses mostly spaced past the debounce interval, with bounces,
  // repeated timestamps, long jumps and the odd unused opcode mixed in.
  task automatic random_requests(int n);
    asgm_pkg::opcode_t op;
    int                pick;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 66)      op = asgm_pkg::OP_PULSE;
      else if (pick < 80) op = asgm_pkg::OP_SPEED;
      else if (pick < 94) op = asgm_pkg::OP_GUST;
      else                op = asgm_pkg::OP_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 65)      clock_ms += board.debounce + 1 + $urandom_range(0, 200);
      else if (pick < 80) clock_ms += $urandom_range(0, board.debounce);
      else if (pick < 96 && pick >= 90) clock_ms += $urandom_range(0, 100000);
      else if (pick >= 96) clock_ms = $urandom;
      send_request(op, clock_ms);
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    asgm_pkg::time_t t0;
    board        = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = asgm_pkg::OP_PULSE;
    time_ms      = '0;
    cfg_we       = 1'b0;
    cfg_index    = asgm_pkg::REG_DEBOUNCE;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_results = 1'b0;
    clock_ms     = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed requests at the reset settings: empty reads, bounces on and just past
    // the debounce limit, period tracking and timestamps wrapping through zero.
    send_request(asgm_pkg::OP_SPEED, 32'd0);
    send_request(asgm_pkg::OP_GUST,  32'd0);
    send_request(asgm_pkg::OP_NONE,  32'hFFFF_FFFF);
    send_request(asgm_pkg::OP_PULSE, 32'd5);
    send_request(asgm_pkg::OP_PULSE, 32'd10);
    send_request(asgm_pkg::OP_PULSE, 32'd11);
    send_request(asgm_pkg::OP_PULSE, 32'd22);
    send_request(asgm_pkg::OP_PULSE, 32'd40);
    send_request(asgm_pkg::OP_PULSE, 32'd60);
    send_request(asgm_pkg::OP_PULSE, 32'd100);
    send_request(asgm_pkg::OP_SPEED, 32'd1000);
    send_request(asgm_pkg::OP_GUST,  32'd1000);
    send_request(asgm_pkg::OP_GUST,  32'd1001);
    send_request(asgm_pkg::OP_PULSE, 32'hFFFF_FFF0);
    send_request(asgm_pkg::OP_PULSE, 32'hFFFF_FFFF);
    send_request(asgm_pkg::OP_PULSE, 32'h0000_0005);
    send_request(asgm_pkg::OP_PULSE, 32'h0000_0010);
    send_request(asgm_pkg::OP_PULSE, 32'h0000_0030);
    send_request(asgm_pkg::OP_SPEED, 32'h8000_0000);
    send_request(asgm_pkg::OP_GUST,  32'h8000_0001);
    send_request(asgm_pkg::OP_NONE,  32'h0000_0000);
    send_request(asgm_pkg::OP_SPEED, 32'h8000_0000);

    // No debounce and full scale: a speed reading over a one-millisecond window
    // overflows and saturates.
    wait_quiet();
    write_register(asgm_pkg::REG_DEBOUNCE, {8'($urandom), 8'h00});
    write_register(asgm_pkg::REG_SCALE, 16'hFFFF);
    t0 = 32'hFFFF_F000;
    send_request(asgm_pkg::OP_SPEED, t0);
    pulse_train(t0 + 1000, 600);
    send_request(asgm_pkg::OP_SPEED, t0 + 1);
    send_request(asgm_pkg::OP_GUST,  t0 + 2);
    send_request(asgm_pkg::OP_SPEED, t0 + 2);
    send_request(asgm_pkg::OP_SPEED, t0 + 200000);
    clock_ms = t0 + 200000;
    random_requests(PHASE_ITEMS);

    // Longest debounce and smallest nonzero scale; the sink holds off so the input backs up.
    wait_quiet();
    write_register(asgm_pkg::REG_DEBOUNCE, {8'($urandom), 8'hFF});
    write_register(asgm_pkg::REG_SCALE, 16'd1);
    hold_results = 1'b1;
    clock_ms     = $urandom;
    random_requests(PHASE_ITEMS);

    wait_quiet();
    write_register(asgm_pkg::REG_DEBOUNCE, 16'($urandom_range(1, 254)));
    write_register(asgm_pkg::REG_SCALE, 16'($urandom_range(2, 65534)));
    clock_ms = $urandom;
    random_requests(PHASE_ITEMS);

    // A zero scale makes every reading nought.
    wait_quiet();
    write_register(asgm_pkg::REG_DEBOUNCE, 16'd10);
    write_register(asgm_pkg::REG_SCALE, 16'd0);
    clock_ms = $urandom;
    random_requests(PHASE_ITEMS);

    wait_quiet();
    write_register(asgm_pkg::REG_DEBOUNCE, 16'($urandom_range(0, 255)));
    write_register(asgm_pkg::REG_SCALE, 16'($urandom_range(1, 65535)));
    clock_ms = $urandom;
    random_requests(PHASE_ITEMS);

    // A turn of zero length, got by stepping back in time; the record then sticks,
    // so this comes last.
    t0 = board.last_pulse + 300;
    if (board.half_turn) begin
      send_request(asgm_pkg::OP_PULSE, t0);
      t0 = t0 + 300;
    end
    send_request(asgm_pkg::OP_PULSE, t0);
    send_request(asgm_pkg::OP_PULSE, t0 + 300);
    send_request(asgm_pkg::OP_PULSE, t0);
    send_request(asgm_pkg::OP_GUST,  t0);
    send_request(asgm_pkg::OP_GUST,  t0 + 1);
    send_request(asgm_pkg::OP_SPEED, t0 + 2);

    wait_quiet();
    if (board.errors == 0) begin
      $display("anemometer_speed_gust_meter_test passed");
    end else begin
      $display("anemometer_speed_gust_meter_test failed");
    end
    $finish;
  end

endmodule
